// ===== rtl/core/ckvp_pkg.sv =====
// Package for the key-value payload parser: phase encoding, status codes,
// result record and the key size decode. Depends on nothing.
`default_nettype none
package ckvp_pkg;

  localparam int unsigned HdrBytes   = 4;
  localparam int unsigned SizeShift  = 28;

  // Size codes held in key bits 31:28.
  localparam logic [3:0] SZ_CODE_BIT1 = 4'h1;
  localparam logic [3:0] SZ_CODE_U8   = 4'h2;
  localparam logic [3:0] SZ_CODE_U16  = 4'h3;
  localparam logic [3:0] SZ_CODE_U32  = 4'h4;
  localparam logic [3:0] SZ_CODE_U64  = 4'h5;

  // End-of-payload status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_KEY    = 4'b0010,
    PH_VALUE  = 4'b0100,
    PH_SKIP   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] key_id;
    logic [63:0] entry_value;
    logic [3:0]  value_bytes;
    logic        message_end;
    logic [1:0]  status;
    logic [7:0]  msg_version;
    logic [7:0]  msg_layer;
    logic [15:0] msg_position;
  } result_t;

  // Value size in bytes for a key; zero for an unknown code.
  function automatic logic [3:0] size_of_key(input logic [31:0] key);
    logic [3:0] code;
    logic [3:0] sz;
    code = key[SizeShift +: 4];
    unique case (code)
      SZ_CODE_BIT1: sz = 4'd1;
      SZ_CODE_U8:   sz = 4'd1;
      SZ_CODE_U16:  sz = 4'd2;
      SZ_CODE_U32:  sz = 4'd4;
      SZ_CODE_U64:  sz = 4'd8;
      default:      sz = 4'd0;
    endcase
    return sz;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/config_key_value_payload_parser.sv =====
// Top level of the configuration key-value payload parser.
// Instantiates ckvp_parse and ckvp_out_reg; uses ckvp_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one payload byte per item, with
//   in_last_byte set on the final byte. Four header bytes (version, layer,
//   little-endian position) come first, then 32-bit little-endian keys,
//   each followed by a 1, 2, 4 or 8 byte little-endian value.
//   Result channel (out_valid/out_ready): an item for each completed entry
//   and one for the final byte; both share one item when the final byte
//   completes a value. out_status is meaningful with out_message_end;
//   entries of a payload that ends with an error status are to be dropped.
//   Throughput: one byte per cycle while the receiver takes results. Each
//   accepted byte updates the parser state in the same cycle and its result
//   lands in the result register, visible in the cycle after acceptance.
//   Stall: while the result register holds an item that is not taken,
//   in_ready drops (combinationally follows out_ready), so no byte is lost.
//   Reset: synchronous, active low; parser returns to the header phase and
//   the result register empties. The final byte of a payload also returns
//   the parser to its reset state.
`default_nettype none
module config_key_value_payload_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_entry_valid,
  output logic [31:0]      out_key_id,
  output logic [63:0]      out_entry_value,
  output logic [3:0]       out_value_bytes,
  output logic             out_message_end,
  output logic [1:0]       out_status,
  output logic [7:0]       out_msg_version,
  output logic [7:0]       out_msg_layer,
  output logic [15:0]      out_msg_position
);

  logic              step;
  logic              res_valid;
  ckvp_pkg::result_t res;
  ckvp_pkg::result_t out_data;
  logic              space;

  // Advance the parser on every accepted byte.
  assign step     = in_valid && in_ready;
  assign in_ready = space;

  ckvp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the result until the receiver takes it.
  ckvp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_entry_valid  = out_data.entry_valid;
  assign out_key_id       = out_data.key_id;
  assign out_entry_value  = out_data.entry_value;
  assign out_value_bytes  = out_data.value_bytes;
  assign out_message_end  = out_data.message_end;
  assign out_status       = out_data.status;
  assign out_msg_version  = out_data.msg_version;
  assign out_msg_layer    = out_data.msg_layer;
  assign out_msg_position = out_data.msg_position;

  // Every result item carries an entry, an end of payload, or both.
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_valid || out_message_end))
    else $error("result item with neither entry nor end");

  // An entry always has one of the legal value sizes.
  a_entry_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_valid) |->
      (out_value_bytes == 4'd1 || out_value_bytes == 4'd2 ||
       out_value_bytes == 4'd4 || out_value_bytes == 4'd8))
    else $error("entry with illegal value size");

  // An entry in the same item as the end means the value completed: status ok.
  a_entry_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_valid && out_message_end) |->
      (out_status == ckvp_pkg::ST_OK))
    else $error("entry with error status");

  // Input is refused only while a result waits and the receiver stalls.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused without a stalled result");

endmodule
`default_nettype wire

// ===== rtl/core/ckvp_parse.sv =====
// Parser state and per-byte update for the key-value payload parser.
// Uses ckvp_pkg for the phase type, status codes and result record.
`default_nettype none
module ckvp_parse (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  output logic                  res_valid,
  output ckvp_pkg::result_t     res
);

  ckvp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] val_r, val_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [7:0]  lay_r, lay_nxt;
  logic [15:0] pos_r, pos_nxt;

  logic [31:0] key_acc;
  logic [63:0] val_acc;
  logic [3:0]  key_sz;
  logic        got_entry;
  logic [1:0]  st;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    len_nxt   = len_r;
    ver_nxt   = ver_r;
    lay_nxt   = lay_r;
    pos_nxt   = pos_r;
    got_entry = 1'b0;
    st        = ckvp_pkg::ST_OK;
    key_acc   = key_r | ({24'd0, data_byte} << {cnt_r[1:0], 3'd0});
    val_acc   = val_r | ({56'd0, data_byte} << {cnt_r, 3'd0});
    key_sz    = ckvp_pkg::size_of_key(key_acc);

    unique case (phase_r)
      ckvp_pkg::PH_HEADER: begin
        unique case (cnt_r[1:0])
          2'd0:    ver_nxt = data_byte;
          2'd1:    lay_nxt = data_byte;
          2'd2:    pos_nxt = {pos_r[15:8], data_byte};
          default: pos_nxt = {data_byte, pos_r[7:0]};
        endcase
        if (cnt_r >= 3'(ckvp_pkg::HdrBytes - 1)) begin
          phase_nxt = ckvp_pkg::PH_KEY;
          cnt_nxt   = 3'd0;
          key_nxt   = 32'd0;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
          st      = ckvp_pkg::ST_SHORT;
        end
      end
      ckvp_pkg::PH_KEY: begin
        key_nxt = key_acc;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt = 3'd0;
          if (key_sz == 4'd0) begin
            phase_nxt = ckvp_pkg::PH_SKIP;
          end else begin
            phase_nxt = ckvp_pkg::PH_VALUE;
            len_nxt   = key_sz;
            val_nxt   = 64'd0;
            st        = ckvp_pkg::ST_TRUNC;
          end
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ckvp_pkg::PH_VALUE: begin
        val_nxt = val_acc;
        if (({1'b0, cnt_r} + 4'd1) >= len_r) begin
          got_entry = 1'b1;
          phase_nxt = ckvp_pkg::PH_KEY;
          cnt_nxt   = 3'd0;
          key_nxt   = 32'd0;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
          st      = ckvp_pkg::ST_TRUNC;
        end
      end
      default: ;
    endcase

    res_valid = step && (got_entry || last_byte);

    res              = '0;
    res.entry_valid  = got_entry;
    res.message_end  = last_byte;
    if (got_entry) begin
      res.key_id      = key_r;
      res.entry_value = val_acc;
      res.value_bytes = len_r;
    end
    if (last_byte) begin
      res.status       = st;
      res.msg_version  = ver_nxt;
      res.msg_layer    = lay_nxt;
      res.msg_position = pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      phase_r <= ckvp_pkg::PH_HEADER;
      cnt_r   <= 3'd0;
      key_r   <= 32'd0;
      val_r   <= 64'd0;
      len_r   <= 4'd0;
      ver_r   <= 8'd0;
      lay_r   <= 8'd0;
      pos_r   <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      key_r   <= key_nxt;
      val_r   <= val_nxt;
      len_r   <= len_nxt;
      ver_r   <= ver_nxt;
      lay_r   <= lay_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ckvp_out_reg.sv =====
// Result register for the key-value payload parser: holds one result item
// until the receiver takes it. Uses ckvp_pkg for the result record.
`default_nettype none
module ckvp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire ckvp_pkg::result_t load_data,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ckvp_pkg::result_t      out_data
);

  logic              full_r, full_nxt;
  ckvp_pkg::result_t data_r;

  assign space = !full_r || out_ready;

  always_comb begin
    priority if (load) full_nxt = 1'b1;
    else if (out_ready) full_nxt = 1'b0;
    else full_nxt = full_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = full_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for config_key_value_payload_parser: streams headers and key-value
// pairs byte by byte, predicts every result, checks results in arrival order.
// Depends on ckvp_pkg and the parser RTL under rtl/core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes    = 1050;
  localparam int unsigned QuietTailBytes = 250;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned LongHold       = 60;
  localparam int unsigned DrainCycles    = 4;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } wire_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_entry_valid;
  logic [31:0] out_key_id;
  logic [63:0] out_entry_value;
  logic [3:0]  out_value_bytes;
  logic        out_message_end;
  logic [1:0]  out_status;
  logic [7:0]  out_msg_version;
  logic [7:0]  out_msg_layer;
  logic [15:0] out_msg_position;

  config_key_value_payload_parser uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_entry_valid  (out_entry_valid),
    .out_key_id       (out_key_id),
    .out_entry_value  (out_entry_value),
    .out_value_bytes  (out_value_bytes),
    .out_message_end  (out_message_end),
    .out_status       (out_status),
    .out_msg_version  (out_msg_version),
    .out_msg_layer    (out_msg_layer),
    .out_msg_position (out_msg_position)
  );

  // Bytes waiting for the driver, and the byte currently on the bus.
  wire_byte_t  tx_q[$];
  bit          byte_pending;
  // Idle bursts on both sides; cleared for the closing stretch.
  bit          bursts_on;
  // Long receiver hold-off: a test posts a length, the sink counts it down.
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned mismatches;

  // Payload under construction by a test.
  logic [7:0]  frame[$];

  // Parser state as predicted from the accepted bytes.
  ckvp_pkg::phase_t  parse_phase;
  logic [2:0]        byte_idx;
  logic [31:0]       key_acc;
  logic [63:0]       value_acc;
  logic [3:0]        value_len;
  logic [7:0]        hdr_version;
  logic [7:0]        hdr_layer;
  logic [15:0]       hdr_position;
  ckvp_pkg::result_t expected_q[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Value width in bytes for a key; zero marks an unknown size code.
  function automatic logic [3:0] value_size(input logic [31:0] key);
    case (key[ckvp_pkg::SizeShift +: 4])
      ckvp_pkg::SZ_CODE_BIT1, ckvp_pkg::SZ_CODE_U8: return 4'd1;
      ckvp_pkg::SZ_CODE_U16:                        return 4'd2;
      ckvp_pkg::SZ_CODE_U32:                        return 4'd4;
      ckvp_pkg::SZ_CODE_U64:                        return 4'd8;
      default:                                      return 4'd0;
    endcase
  endfunction

  task automatic clear_parser();
    parse_phase  = ckvp_pkg::PH_HEADER;
    byte_idx     = '0;
    key_acc      = '0;
    value_acc    = '0;
    value_len    = '0;
    hdr_version  = '0;
    hdr_layer    = '0;
    hdr_position = '0;
  endtask

  // Advance the predicted state by one accepted byte; queue the result it causes.
  task automatic predict_byte(input logic [7:0] b, input logic last);
    ckvp_pkg::result_t r;
    logic              got;
    logic [1:0]        st;
    logic [3:0]        sz;
    r   = '0;
    got = 1'b0;
    st  = ckvp_pkg::ST_OK;
    case (parse_phase)
      ckvp_pkg::PH_HEADER: begin
        // Version, layer, then the position word low byte first.
        case (byte_idx)
          3'd0:    hdr_version = b;
          3'd1:    hdr_layer = b;
          3'd2:    hdr_position[7:0] = b;
          default: hdr_position[15:8] = b;
        endcase
        if (byte_idx >= 3'(ckvp_pkg::HdrBytes - 1)) begin
          parse_phase = ckvp_pkg::PH_KEY;
          byte_idx    = '0;
          key_acc     = '0;
        end else begin
          byte_idx = byte_idx + 3'd1;
          st       = ckvp_pkg::ST_SHORT;
        end
      end
      ckvp_pkg::PH_KEY: begin
        key_acc = key_acc | (32'(b) << (8 * byte_idx[1:0]));
        if (byte_idx[1:0] == 2'd3) begin
          sz       = value_size(key_acc);
          byte_idx = '0;
          if (sz == 4'd0) begin
            // Unknown size: ignore the rest of the payload.
            parse_phase = ckvp_pkg::PH_SKIP;
          end else begin
            parse_phase = ckvp_pkg::PH_VALUE;
            value_len   = sz;
            value_acc   = '0;
            st          = ckvp_pkg::ST_TRUNC;
          end
        end else begin
          byte_idx = byte_idx + 3'd1;
        end
      end
      ckvp_pkg::PH_VALUE: begin
        value_acc = value_acc | (64'(b) << (8 * byte_idx));
        if ({1'b0, byte_idx} + 4'd1 >= value_len) begin
          got           = 1'b1;
          r.entry_valid = 1'b1;
          r.key_id      = key_acc;
          r.entry_value = value_acc;
          r.value_bytes = value_len;
          parse_phase   = ckvp_pkg::PH_KEY;
          byte_idx      = '0;
          key_acc       = '0;
        end else begin
          byte_idx = byte_idx + 3'd1;
          st       = ckvp_pkg::ST_TRUNC;
        end
      end
      default: begin
      end
    endcase
    if (got || last) begin
      if (last) begin
        r.message_end  = 1'b1;
        r.status       = st;
        r.msg_version  = hdr_version;
        r.msg_layer    = hdr_layer;
        r.msg_position = hdr_position;
        // The final byte returns the parser to its reset state.
        clear_parser();
      end
      expected_q.insert(expected_q.size(), r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: drive at the falling edge, take acceptance at the rising edge
  // ---------------------------------------------------------------------------
  initial begin : byte_driver
    wire_byte_t  nxt;
    int unsigned gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && in_valid && in_ready === 1'b1) begin
        predict_byte(in_data_byte, in_last_byte);
        byte_pending = 1'b0;
      end
      @(negedge clk);
      // Hold the current byte until it is taken.
      if (!byte_pending) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid     <= 1'b0;
          in_data_byte <= 8'($urandom);
          in_last_byte <= 1'($urandom);
        end else if (tx_q.size() > 0) begin
          nxt          = tx_q.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= nxt.data;
          in_last_byte <= nxt.last;
          byte_pending = 1'b1;
          if (bursts_on && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: check each taken result, then pick the next ready level
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial begin : result_sink
    int unsigned       stall_left;
    ckvp_pkg::result_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: key_id %0h message_end %0b",
                 out_key_id, out_message_end);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          compare_field("entry_valid", want.entry_valid, out_entry_valid);
          compare_field("key_id", want.key_id, out_key_id);
          compare_field("entry_value", want.entry_value, out_entry_value);
          compare_field("value_bytes", want.value_bytes, out_value_bytes);
          compare_field("message_end", want.message_end, out_message_end);
          compare_field("status", want.status, out_status);
          compare_field("msg_version", want.msg_version, out_msg_version);
          compare_field("msg_layer", want.msg_layer, out_msg_layer);
          compare_field("msg_position", want.msg_position, out_msg_position);
        end
      end
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        // Long hold-off: let the result register fill and stall the input.
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // End the run when neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Payload building and sending
  // ---------------------------------------------------------------------------

  // Queue one byte for the driver; keep the backlog short.
  task automatic send_byte(input logic [7:0] data, input logic last);
    wire_byte_t wb;
    while (tx_q.size() >= 2) @(posedge clk);
    wb.last = last;
    wb.data = data;
    tx_q.insert(tx_q.size(), wb);
  endtask

  // Append one byte to the payload under construction.
  task automatic frame_add(input logic [7:0] b);
    frame.insert(frame.size(), b);
  endtask

  // Send the built payload, flagging its final byte.
  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
    frame.delete();
  endtask

  task automatic add_header(input logic [7:0] version, input logic [7:0] layer,
                            input logic [15:0] position);
    frame_add(version);
    frame_add(layer);
    frame_add(position[7:0]);
    frame_add(position[15:8]);
  endtask

  // Append a little-endian field of n bytes.
  task automatic add_le(input logic [63:0] v, input int unsigned n);
    for (int i = 0; i < n; i++) frame_add(v[8 * i +: 8]);
  endtask

  task automatic add_random(input int unsigned n);
    repeat (n) frame_add(8'($urandom));
  endtask

  function automatic logic [31:0] pick_key(input bit known);
    logic [3:0] code;
    if (known) begin
      code = 4'($urandom_range(ckvp_pkg::SZ_CODE_BIT1, ckvp_pkg::SZ_CODE_U64));
    end else begin
      code = 4'($urandom);
      while (code >= ckvp_pkg::SZ_CODE_BIT1 && code <= ckvp_pkg::SZ_CODE_U64)
        code = 4'($urandom);
    end
    return {code, 28'($urandom)};
  endfunction

  // Wait until every queued byte is taken and every expected result has come.
  task automatic wait_drained();
    while (tx_q.size() != 0 || byte_pending || expected_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Final byte inside the header: short status, missing header bytes read zero.
  task automatic test_short_payloads();
    frame_add(8'hFF);
    send_frame();
    frame_add(8'h00);
    frame_add(8'hFF);
    frame_add(8'hA5);
    send_frame();
  endtask

  task automatic test_header_only();
    add_header(8'h01, 8'hFF, 16'hA55A);
    send_frame();
  endtask

  // One pair per size code; the last value completes on the final byte.
  task automatic test_each_value_size();
    add_header(8'h00, 8'h00, 16'h0000);
    add_le({ckvp_pkg::SZ_CODE_BIT1, 28'h0000001}, 4);
    add_le(64'h01, 1);
    add_le({ckvp_pkg::SZ_CODE_U8, 28'hFFFFFFF}, 4);
    add_le(64'hFF, 1);
    add_le({ckvp_pkg::SZ_CODE_U16, 28'h1234567}, 4);
    add_le(64'h8001, 2);
    add_le({ckvp_pkg::SZ_CODE_U32, 28'h0000000}, 4);
    add_le(64'hFFFF_FFFF, 4);
    add_le({ckvp_pkg::SZ_CODE_U64, 28'hFFFFFFF}, 4);
    add_le(64'h8000_0000_0000_0001, 8);
    send_frame();
  endtask

  // Unknown size code: skip the rest, also when the key ends the payload.
  task automatic test_unknown_size_code();
    add_header(8'h7E, 8'h81, 16'hFFFF);
    add_le({ckvp_pkg::SZ_CODE_U8, 28'h0ABCDEF}, 4);
    add_le(64'h5A, 1);
    add_le({4'h0, 28'h0000000}, 4);
    add_le(64'h05_0000_1234, 5);
    send_frame();
    add_header(8'h10, 8'h20, 16'h0300);
    add_le({4'hF, 28'hFFFFFFF}, 4);
    send_frame();
  endtask

  // Known key completing on the final byte: truncated status.
  task automatic test_key_then_end();
    add_header(8'h02, 8'h03, 16'h0405);
    add_le({ckvp_pkg::SZ_CODE_U32, 28'h0000042}, 4);
    send_frame();
  endtask

  // Drop one to three trailing key bytes without error.
  task automatic test_leftover_key_bytes();
    for (int n = 1; n <= 3; n++) begin
      add_header(8'($urandom), 8'($urandom), 16'($urandom));
      add_le({ckvp_pkg::SZ_CODE_U16, 28'($urandom)}, 4);
      add_le(64'($urandom), 2);
      add_random(n);
      send_frame();
    end
  endtask

  // Final byte inside a value: truncated status and no entry.
  task automatic test_cut_off_value();
    add_header(8'hC3, 8'h3C, 16'h00FF);
    add_le({ckvp_pkg::SZ_CODE_U64, 28'h0000099}, 4);
    add_random(5);
    send_frame();
    wait_drained();
  endtask

  // Hold the receiver off while the sender keeps offering a long payload.
  task automatic test_output_backpressure();
    logic [31:0] key;
    hold_request = LongHold;
    add_header(8'($urandom), 8'($urandom), 16'($urandom));
    repeat (6) begin
      key = pick_key(1'b1);
      add_le(key, 4);
      add_le({$urandom, $urandom}, value_size(key));
    end
    send_frame();
    while (hold_request != 0 || hold_left != 0) @(posedge clk);
    wait_drained();
  endtask

  // Mostly well-formed payloads with random content, plus broken ones and noise.
  task automatic test_random_payloads(input int unsigned budget);
    int unsigned counted;
    int unsigned kind;
    int unsigned pairs;
    logic [31:0] key;
    counted = 0;
    while (counted < budget) begin
      kind  = $urandom_range(0, 99);
      pairs = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      add_header(8'($urandom), 8'($urandom), 16'($urandom));
      for (int i = 0; i < pairs; i++) begin
        key = pick_key(1'b1);
        add_le(key, 4);
        add_le({$urandom, $urandom}, value_size(key));
      end
      if (kind < 55) begin
        // End on a complete value, or on the header alone.
      end else if (kind < 65) begin
        add_random($urandom_range(1, 3));
      end else if (kind < 77) begin
        key = pick_key(1'b1);
        add_le(key, 4);
        add_random($urandom_range(0, value_size(key) - 1));
      end else if (kind < 87) begin
        add_le(pick_key(1'b0), 4);
        // Skipped bytes do not count toward the budget.
        counted += frame.size();
        add_random($urandom_range(0, 8));
      end else if (kind < 94) begin
        frame.delete();
        add_random($urandom_range(1, 3));
      end else begin
        frame.delete();
        add_random($urandom_range(1, 24));
      end
      if (kind < 77 || kind >= 87) counted += frame.size();
      send_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    out_ready    = 1'b0;
    byte_pending = 1'b0;
    bursts_on    = 1'b1;
    hold_request = 0;
    hold_left    = 0;
    mismatches   = 0;
    clear_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_payloads();
    test_header_only();
    test_each_value_size();
    test_unknown_size_code();
    test_key_then_end();
    test_leftover_key_bytes();
    test_cut_off_value();
    test_output_backpressure();
    test_random_payloads(RandomBytes - QuietTailBytes);
    // Close with back-to-back traffic on both sides.
    bursts_on = 1'b0;
    test_random_payloads(QuietTailBytes);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
